// File: rtl/pwsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsr_pkg
// shared widths, register indexes and the result type of the receiver
// ----------------------------------------------------------------------------
package pwsr_pkg;

    // pulse width counter, reference width and threshold width
    localparam int COUNT_WIDTH = 8;

    localparam int BYTE_WIDTH  = 8;
    localparam int CFG_WIDTH   = 8;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  last_byte;
        logic                  frame_error;
    } result_t;

endpackage

// File: rtl/pulse_width_serial_receiver_unit.sv
`timescale 1ns / 1ps
// a result is registered into the result register, or into the skid entry while that one holds an untaken result
// throughput: one line sample per cycle, every cycle, while the skid entry is free
// s_tready drops only when the result register and the skid entry both hold a result
// reset: rst_n asynchronous, active low; decoder idles with line assumed high,
// byte_capacity and timeout_ticks both return to 255
// ----------------------------------------------------------------------------
// pulse_width_serial_receiver_unit
// single-wire pulse width coded frame receiver, one line sample per request
// ----------------------------------------------------------------------------
module pulse_width_serial_receiver_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pwsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwsr_pkg::CFG_WIDTH-1:0]     cfg_data,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] line_level, rest zero
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] data_byte
    output logic                               m_tlast,   // last_byte
    output logic                               m_tuser    // [0] frame_error
);

    logic              accept;
    logic              res_valid;
    pwsr_pkg::result_t res;
    pwsr_pkg::result_t out_data;

    // a request is taken whenever the skid entry is free
    assign accept = s_tvalid && s_tready;

    // decoder state advances once per accepted sample; upper tdata bits are padding
    pwsr_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (accept),
        .sample_level (s_tdata[0]),
        .res_valid    (res_valid),
        .res          (res)
    );

    // result register plus skid entry parts the two handshakes
    pwsr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.data_byte;
    assign m_tlast = out_data.last_byte;
    assign m_tuser = out_data.frame_error;

endmodule

// File: rtl/pwsr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsr_core
// per-sample frame decoder: pulse width measure, threshold and byte assembly
// ----------------------------------------------------------------------------
module pwsr_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pwsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pwsr_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                  sample_valid,
    input  logic                                  sample_level,
    output logic                                  res_valid,
    output pwsr_pkg::result_t                     res
);

    localparam int CW = pwsr_pkg::COUNT_WIDTH;
    localparam int BW = pwsr_pkg::BYTE_WIDTH;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_REF0 = 3'd1;
    localparam logic [2:0] PH_REF1 = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_SEP  = 3'd4;

    logic [BW-1:0] capacity_reg;
    logic [pwsr_pkg::CFG_WIDTH-1:0] timeout_reg;

    logic [2:0]    phase_reg,     phase_next;
    logic          prev_reg,      prev_next;
    logic [CW-1:0] width_reg,     width_next;
    logic [CW-1:0] ref0_reg,      ref0_next;
    logic [CW-1:0] thresh_reg,    thresh_next;
    logic [BW-1:0] shift_reg,     shift_next;
    logic [2:0]    bit_idx_reg,   bit_idx_next;
    logic [BW-1:0] count_reg,     count_next;

    logic          timed_out;
    logic          wide;
    logic [CW:0]   ref_sum;
    logic [BW-1:0] count_inc;
    logic          last;

    // timeout compare done at a width that holds both operands
    assign timed_out = ({{pwsr_pkg::CFG_WIDTH{1'b0}}, width_reg}
                        >= {{CW{1'b0}}, timeout_reg}) || (width_reg == {CW{1'b1}});
    assign wide      = width_reg > thresh_reg;
    assign ref_sum   = {1'b0, ref0_reg} + {1'b0, width_reg};
    assign count_inc = count_reg + {{(BW-1){1'b0}}, 1'b1};
    assign last      = wide || (count_inc >= capacity_reg) || (count_inc == '0);

    always_comb
    begin
        phase_next   = phase_reg;
        prev_next    = prev_reg;
        width_next   = width_reg;
        ref0_next    = ref0_reg;
        thresh_next  = thresh_reg;
        shift_next   = shift_reg;
        bit_idx_next = bit_idx_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (sample_valid)
        begin
            prev_next = sample_level;
            if (phase_reg == PH_IDLE)
            begin
                if (prev_reg && !sample_level)
                begin
                    phase_next   = PH_REF0;
                    width_next   = '0;
                    shift_next   = '0;
                    bit_idx_next = 3'd7;
                    count_next   = '0;
                end
            end
            else if (sample_level)
            begin
                if (timed_out)
                begin
                    phase_next      = PH_IDLE;
                    width_next      = '0;
                    res_valid       = 1'b1;
                    res.frame_error = 1'b1;
                end
                else
                begin
                    width_next = width_reg + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            else if (prev_reg)
            begin
                // falling edge closes a pulse
                width_next = '0;
                case (phase_reg)
                    PH_REF0:
                    begin
                        ref0_next  = width_reg;
                        phase_next = PH_REF1;
                    end
                    PH_REF1:
                    begin
                        thresh_next = ref_sum[CW:1];
                        phase_next  = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (wide)
                            shift_next = shift_reg | (BW'(1) << bit_idx_reg);
                        if (bit_idx_reg == 3'd0)
                        begin
                            bit_idx_next = 3'd7;
                            phase_next   = PH_SEP;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg - 3'd1;
                        end
                    end
                    PH_SEP:
                    begin
                        count_next    = count_inc;
                        res_valid     = 1'b1;
                        res.data_byte = shift_reg;
                        res.last_byte = last;
                        shift_next    = '0;
                        phase_next    = last ? PH_IDLE : PH_DATA;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '1;
            timeout_reg  <= '1;
            phase_reg    <= PH_IDLE;
            prev_reg     <= 1'b1;
            width_reg    <= '0;
            ref0_reg     <= '0;
            thresh_reg   <= '0;
            shift_reg    <= '0;
            bit_idx_reg  <= 3'd7;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == pwsr_pkg::REG_BYTE_CAPACITY)
                capacity_reg <= cfg_data;
            if (cfg_we && cfg_index == pwsr_pkg::REG_TIMEOUT_TICKS)
                timeout_reg <= cfg_data;
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            width_reg   <= width_next;
            ref0_reg    <= ref0_next;
            thresh_reg  <= thresh_next;
            shift_reg   <= shift_next;
            bit_idx_reg <= bit_idx_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: rtl/pwsr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsr_out_buf
// result register with a skid entry so the input side's ready comes from a register, not from tready
// ----------------------------------------------------------------------------
module pwsr_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pwsr_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output pwsr_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    pwsr_pkg::result_t out_reg;
    pwsr_pkg::result_t skid_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= push_data;
            else
                out_reg <= push_data;
        end
    end

endmodule

// File: verif/pulse_width_serial_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_serial_receiver_unit_tb
// drives line samples as pulse-width coded frames, noise and timeouts,
// predicts every byte and error word, and checks them in order of arrival
// ----------------------------------------------------------------------------
module pulse_width_serial_receiver_unit_tb;

    localparam int CNT_MAX        = (1 << pwsr_pkg::COUNT_WIDTH) - 1;
    localparam int GAP_PERCENT    = 26;
    // receiver hold-off, long enough that result register and skid entry fill up
    localparam int HOLD_CYCLES    = 400;
    // cycles with no request on either side; hold-off plus margin, several times over
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SAMPLES = 400;
    localparam int PHASE_SAMPLES  = 80;
    localparam int NO_GAP_SAMPLES = 150;

    // decoder mirror phase codes
    localparam logic [2:0] DEC_IDLE = 3'd0;
    localparam logic [2:0] DEC_REF0 = 3'd1;
    localparam logic [2:0] DEC_REF1 = 3'd2;
    localparam logic [2:0] DEC_DATA = 3'd3;
    localparam logic [2:0] DEC_SEP  = 3'd4;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pwsr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwsr_pkg::CFG_WIDTH-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;    // [0] line_level, rest zero
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;    // [7:0] data_byte
    logic                           m_tlast;    // last_byte
    logic                           m_tuser;    // [0] frame_error

    // decoder mirror, updated on every accepted line sample
    logic [2:0]                       dec_phase;
    logic                             prev_level;
    logic [pwsr_pkg::COUNT_WIDTH-1:0] pulse_cnt;
    logic [pwsr_pkg::COUNT_WIDTH-1:0] ref0_width;
    logic [pwsr_pkg::COUNT_WIDTH-1:0] thr;
    logic [7:0]                       shift_reg;
    logic [2:0]                       bit_pos;
    logic [7:0]                       byte_cnt;
    logic [7:0]                       cap_reg;
    logic [7:0]                       tmo_reg;

    pwsr_pkg::result_t expected_bytes[$];

    int  samples_sent   = 0;
    int  mismatch_count = 0;
    int  stall_cycles   = 0;
    int  hold_left      = 0;
    bit  hold_req       = 1'b0;
    bit  tx_gaps        = 1'b1;
    bit  rx_gaps        = 1'b1;

    pulse_width_serial_receiver_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // one line sample through the decoder; pushes the word it completes, if any
    task automatic decode_sample(input logic lvl);
        logic                             was_high;
        logic [pwsr_pkg::COUNT_WIDTH-1:0] w;
        logic [pwsr_pkg::COUNT_WIDTH:0]   ref_sum;
        logic [7:0]                       nxt_cnt;
        logic                             is_last;
        pwsr_pkg::result_t                r;
        was_high   = prev_level;
        prev_level = lvl;
        if (dec_phase == DEC_IDLE)
        begin
            // falling edge in idle opens a frame
            if (was_high && !lvl)
            begin
                dec_phase = DEC_REF0;
                pulse_cnt = '0;
                shift_reg = '0;
                bit_pos   = 3'd7;
                byte_cnt  = '0;
            end
        end
        else if (lvl)
        begin
            // high tick: count, or abort once the width hits the timeout or wraps
            if (pulse_cnt >= tmo_reg || pulse_cnt == CNT_MAX)
            begin
                dec_phase     = DEC_IDLE;
                pulse_cnt     = '0;
                r.data_byte   = '0;
                r.last_byte   = 1'b0;
                r.frame_error = 1'b1;
                expected_bytes.push_back(r);
            end
            else
            begin
                pulse_cnt = pulse_cnt + 1'b1;
            end
        end
        else if (was_high)
        begin
            // falling edge closes a pulse; steady low does nothing
            w         = pulse_cnt;
            pulse_cnt = '0;
            case (dec_phase)
                DEC_REF0:
                begin
                    ref0_width = w;
                    dec_phase  = DEC_REF1;
                end
                DEC_REF1:
                begin
                    ref_sum   = {1'b0, ref0_width} + {1'b0, w};
                    thr       = ref_sum[pwsr_pkg::COUNT_WIDTH:1];
                    dec_phase = DEC_DATA;
                end
                DEC_DATA:
                begin
                    if (w > thr)
                        shift_reg[bit_pos] = 1'b1;
                    if (bit_pos == 3'd0)
                    begin
                        bit_pos   = 3'd7;
                        dec_phase = DEC_SEP;
                    end
                    else
                    begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                DEC_SEP:
                begin
                    nxt_cnt       = byte_cnt + 1'b1;
                    is_last       = (w > thr) || (nxt_cnt >= cap_reg)
                                    || (nxt_cnt == 8'd0);
                    byte_cnt      = nxt_cnt;
                    r.data_byte   = shift_reg;
                    r.last_byte   = is_last;
                    r.frame_error = 1'b0;
                    expected_bytes.push_back(r);
                    shift_reg     = '0;
                    dec_phase     = is_last ? DEC_IDLE : DEC_DATA;
                end
                default:
                    dec_phase = DEC_IDLE;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------

    // one line sample request, after random idle cycles
    task automatic send_sample(input logic lvl);
        while (tx_gaps && $urandom_range(99, 0) < GAP_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        do @(posedge clk); while (!s_tready);
        decode_sample(lvl);
        samples_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_sample(lvl);
    endtask

    // high pulse of the given width followed by a short low
    task automatic send_pulse(input int hi);
        send_run(1'b1, hi);
        send_run(1'b0, $urandom_range(3, 1));
    endtask

    // width for a coded bit; the threshold itself and one above it come often
    function automatic int bit_width(input bit one, input int thr_w, input int one_w);
        if (one)
            return $urandom_range(1, 0) ? thr_w + 1 : $urandom_range(one_w, thr_w + 1);
        return $urandom_range(1, 0) ? thr_w : $urandom_range(thr_w, 1);
    endfunction

    // widths for a frame that fit under the current timeout
    task automatic pick_widths(output int zero_w, output int one_w);
        int max_w;
        max_w = (tmo_reg < 12) ? tmo_reg : 12;
        if (max_w < 2)
        begin
            zero_w = 1;
            one_w  = 1;
        end
        else
        begin
            zero_w = $urandom_range(max_w - 1, 1);
            one_w  = $urandom_range(max_w, zero_w + 1);
        end
    endtask

    // line high then low: the falling edge opens a frame when idle
    task automatic send_frame_start();
        send_run(1'b1, $urandom_range(2, 1));
        send_run(1'b0, $urandom_range(3, 1));
    endtask

    // reference pulses, then each byte MSB first with its separator
    task automatic send_frame_body(input int zero_w, input int one_w, input int nbytes,
                                   input logic [7:0] first_byte, input bit end_wide);
        int         thr_w;
        logic [7:0] data;
        thr_w = (zero_w + one_w) / 2;
        send_pulse(zero_w);
        send_pulse(one_w);
        for (int b = 0; b < nbytes; b++)
        begin
            data = (b == 0) ? first_byte : 8'($urandom_range(255, 0));
            for (int i = 7; i >= 0; i--)
                send_pulse(bit_width(data[i], thr_w, one_w));
            send_pulse(bit_width(end_wide && (b == nbytes - 1), thr_w, one_w));
        end
    endtask

    task automatic send_frame(input int zero_w, input int one_w, input int nbytes,
                              input logic [7:0] first_byte, input bit end_wide);
        send_frame_start();
        send_frame_body(zero_w, one_w, nbytes, first_byte, end_wide);
    endtask

    // stop offering samples and wait until every expected word is out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // a result is registered after its sample, and may wait in the skid entry
        repeat (4) @(posedge clk);
    endtask

    // both registers, only once every expected word is out
    task automatic configure(input int cap, input int tmo);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= pwsr_pkg::REG_BYTE_CAPACITY;
        cfg_data  <= 8'(cap);
        @(posedge clk);
        cfg_index <= pwsr_pkg::REG_TIMEOUT_TICKS;
        cfg_data  <= 8'(tmo);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_reg    = 8'(cap);
        tmo_reg    = 8'(tmo);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch %s at %0t: expected %0h got %0h", field, $realtime, want, got);
        mismatch_count++;
    endtask

    // receiver ready: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !(rx_gaps && $urandom_range(99, 0) < GAP_PERCENT);
        end
    end

    // every result request against the oldest expected word
    always @(posedge clk)
    begin : check_result
        pwsr_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected result", 0, m_tdata);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data_byte)
                    report_mismatch("data_byte", want.data_byte, m_tdata);
                if (m_tlast !== want.last_byte)
                    report_mismatch("last_byte", want.last_byte, m_tlast);
                if (m_tuser !== want.frame_error)
                    report_mismatch("frame_error", want.frame_error, m_tuser);
            end
        end
    end

    // no request on either side for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pulse_width_serial_receiver_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // idle highs and steady lows, extreme bytes, bits on the threshold
    task automatic test_idle_and_bits();
        send_frame(2, 6, 1, 8'h00, 1'b1);
        send_run(1'b0, 5);
        send_run(1'b1, 5);
        send_frame(2, 6, 2, 8'hFF, 1'b1);
        send_frame(1, 9, 1, 8'hA5, 1'b1);
    endtask

    // pulse exactly at the timeout passes, one tick more aborts;
    // the falling edge that ends the long pulse opens the next frame
    task automatic test_timeout();
        configure(255, 3);
        send_frame_start();
        send_pulse(3);
        send_run(1'b1, 4);
        send_run(1'b0, 2);
        send_frame_body(1, 3, 1, 8'h5A, 1'b1);
        // counter at its top value with the largest timeout
        configure(255, 255);
        send_frame_start();
        send_pulse(2);
        send_run(1'b1, 256);
        send_run(1'b0, 1);
        send_frame_body(2, 5, 1, 8'h3C, 1'b1);
    endtask

    // a low line never times out
    task automatic test_long_low();
        send_run(1'b1, 1);
        send_run(1'b0, 270);
        send_frame_body(3, 7, 1, 8'h96, 1'b1);
    endtask

    // byte count reaching the capacity cuts the frame; the rest reads as a new frame
    task automatic test_capacity_cut();
        configure(1, 20);
        send_frame(2, 5, 3, 8'h81, 1'b0);
        configure(2, 20);
        send_frame(2, 5, 3, 8'h7E, 1'b0);
        send_run(1'b1, 25);
        send_run(1'b0, 2);
    endtask

    // receiver holds off while a frame keeps coming, then sender waits for all words
    task automatic test_backpressure();
        configure(255, 255);
        hold_req = 1'b1;
        send_frame(1, 2, 4, 8'hC3, 1'b1);
        settle();
    endtask

    // one chunk of random traffic: mostly clean frames, some broken ones and noise
    task automatic random_burst();
        int pick;
        int zero_w;
        int one_w;
        pick = $urandom_range(99, 0);
        pick_widths(zero_w, one_w);
        if (pick < 75)
        begin
            send_frame(zero_w, one_w, $urandom_range(4, 1), 8'($urandom_range(255, 0)),
                       $urandom_range(99, 0) < 85);
        end
        else if (pick < 85)
        begin
            // frame cut short in the middle of its bits
            send_frame_start();
            send_pulse(zero_w);
            send_pulse(one_w);
            repeat ($urandom_range(12, 1)) send_pulse($urandom_range(one_w, 1));
        end
        else if (pick < 93)
        begin
            send_run(1'b1, tmo_reg + $urandom_range(3, 1));
            send_run(1'b0, $urandom_range(3, 1));
        end
        else
        begin
            repeat ($urandom_range(24, 8)) send_sample(1'($urandom_range(1, 0)));
        end
    endtask

    // sample and result sides with no gaps at all for a stretch
    task automatic test_no_gaps();
        int start_cnt;
        configure(8, 30);
        tx_gaps   = 1'b0;
        rx_gaps   = 1'b0;
        start_cnt = samples_sent;
        while (samples_sent - start_cnt < NO_GAP_SAMPLES)
            random_burst();
        settle();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // random traffic across several register settings, extremes first
    task automatic test_random_traffic();
        int base_samples;
        int phase_start;
        int ph;
        base_samples = samples_sent;
        ph           = 0;
        while (samples_sent - base_samples < RANDOM_SAMPLES)
        begin
            case (ph)
                0:       configure(255, 255);
                1:       configure(1, 12);
                2:       configure(4, 1);
                3:       configure(255, 2);
                4:       configure(2, 6);
                default: configure($urandom_range(1, 0) ? $urandom_range(8, 1)
                                                        : $urandom_range(255, 1),
                                   $urandom_range(40, 1));
            endcase
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_SAMPLES)
                random_burst();
            ph++;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        // decoder state after reset; line assumed high
        dec_phase  = DEC_IDLE;
        prev_level = 1'b1;
        pulse_cnt  = '0;
        ref0_width = '0;
        thr        = '0;
        shift_reg  = '0;
        bit_pos    = 3'd7;
        byte_cnt   = '0;
        cap_reg    = 8'd255;
        tmo_reg    = 8'd255;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_bits();
        test_timeout();
        test_long_low();
        test_capacity_cut();
        test_backpressure();
        test_no_gaps();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("pulse_width_serial_receiver_unit verification clean");
        else
            $display("pulse_width_serial_receiver_unit verification failed");
        $finish;
    end

endmodule

// File: pulse_width_serial_receiver_unit.f
rtl/pwsr_pkg.sv
rtl/pwsr_core.sv
rtl/pwsr_out_buf.sv
rtl/pulse_width_serial_receiver_unit.sv
verif/pulse_width_serial_receiver_unit_tb.sv
